@@ sv/slwc_pkg.sv @@
// ----------------------------------------------------------------------------
// slwc_pkg: shared definitions of the sliding window counter limiter
// Field widths, register indexes, command codes and the control word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package slwc_pkg;

	localparam int WINDOW_BITS    = 24;
	localparam int MAX_BITS       = 16;
	localparam int INDEX_BITS     = 4;
	localparam int NOW_BITS       = 32;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX    = 1'd1;

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 24'd60;
	localparam logic [MAX_BITS-1:0]    MAX_RESET    = 16'd10;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_ERASE = 1'b1;

	// Control word of the multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;  // load the product register with a * b
		logic acc_en;  // update the accumulator from the product register
		logic acc_add; // add to the accumulator instead of loading it
	} mac_ctl_t;

endpackage

@@ sv/slwc_mac.sv @@
// ----------------------------------------------------------------------------
// slwc_mac: shared multiply-accumulate unit
// One registered multiplier feeding an accumulator, with a compare of the
// accumulated sum against the last product.
// ----------------------------------------------------------------------------
module slwc_mac #(
	parameter int A_BITS = 16
) (
	input  logic                             clk,
	input  slwc_pkg::mac_ctl_t               ctl,
	input  logic [A_BITS-1:0]                a,
	input  logic [slwc_pkg::WINDOW_BITS-1:0] b,
	output logic                             less
);

	localparam int PROD_BITS = A_BITS + slwc_pkg::WINDOW_BITS;
	localparam int ACC_BITS  = PROD_BITS + 1;

	logic [PROD_BITS-1:0] prod_q;
	logic [ACC_BITS-1:0]  acc_q;
	logic [ACC_BITS-1:0]  acc_base;

	assign acc_base = ctl.acc_add ? acc_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= PROD_BITS'(a) * PROD_BITS'(b);
		end
		if (ctl.acc_en) begin
			acc_q <= acc_base + ACC_BITS'(prod_q);
		end
	end

	assign less = acc_q < ACC_BITS'(prod_q);

endmodule

@@ sv/sliding_window_counter_limiter.sv @@
// ----------------------------------------------------------------------------
// sliding_window_counter_limiter: per-client sliding window rate limiter
// Each command checks a request for a client slot against a weighted count
// of the previous and current windows, or erases the slot.
// ----------------------------------------------------------------------------
//
// Channel   Handshake           Payload
// command   start / busy        command, client_index, now_time
// result    done (one cycle)    allowed
// config    cfg_write           cfg_index, cfg_data
//
// A request check runs from its transfer to the next possible transfer
// through a memory read, the window update, three products formed one after
// another on the single shared multiplier, and the compare with write-back.
// An erase or an out-of-range slot answers in the cycle after its transfer
// and leaves busy low, so such commands can follow every cycle.
// After reset a clearing pass marks every slot absent; busy stays high
// meanwhile. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module sliding_window_counter_limiter #(
	parameter int CLIENTS    = 16,
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [slwc_pkg::INDEX_BITS-1:0]     client_index,
	input  logic [slwc_pkg::NOW_BITS-1:0]       now_time,
	output logic                                done,
	output logic                                allowed,
	input  logic                                cfg_write,
	input  logic [slwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [slwc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int IDX_BITS   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int ENTRY_BITS = 1 + 2 * COUNT_BITS + TIME_BITS;
	localparam int MUL_A_BITS = (COUNT_BITS > slwc_pkg::MAX_BITS) ?
		COUNT_BITS : slwc_pkg::MAX_BITS;
	localparam int CMP_BITS   = (TIME_BITS > slwc_pkg::WINDOW_BITS) ?
		TIME_BITS : slwc_pkg::WINDOW_BITS;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_MUL1  = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_MUL3  = 3'd6;
	localparam logic [2:0] ST_CMP   = 3'd7;

	logic [2:0]                       state_q;
	logic [IDX_BITS-1:0]              clr_idx_q;
	logic [IDX_BITS-1:0]              slot_q;
	logic [TIME_BITS-1:0]             now_q;
	logic [slwc_pkg::WINDOW_BITS-1:0] window_q;
	logic [slwc_pkg::MAX_BITS-1:0]    max_q;
	logic                             done_q;
	logic                             allowed_q;

	logic [COUNT_BITS-1:0]            prev_q;
	logic [COUNT_BITS-1:0]            curr_q;
	logic [TIME_BITS-1:0]             begin_q;
	logic [slwc_pkg::WINDOW_BITS-1:0] e_q;

	logic [ENTRY_BITS-1:0] mem [CLIENTS];
	logic [ENTRY_BITS-1:0] rd_q;
	logic                  mem_we;
	logic [IDX_BITS-1:0]   mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata;

	logic                  accept;
	logic                  in_range;
	logic [IDX_BITS-1:0]   in_idx;

	logic                  pres_r;
	logic [COUNT_BITS-1:0] prev_r;
	logic [COUNT_BITS-1:0] curr_r;
	logic [TIME_BITS-1:0]  begin_r;
	logic [TIME_BITS-1:0]  begin_eff;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  roll;

	logic                             less;
	logic                             allow;
	logic [COUNT_BITS-1:0]            curr_next;
	slwc_pkg::mac_ctl_t               mac_ctl;
	logic [MUL_A_BITS-1:0]            mac_a;
	logic [slwc_pkg::WINDOW_BITS-1:0] mac_b;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = 32'(client_index) < 32'(CLIENTS);
	assign in_idx   = IDX_BITS'(client_index);
	assign done     = done_q;
	assign allowed  = allowed_q;

	// Unpack the stored record of the slot under work.
	assign pres_r  = rd_q[ENTRY_BITS-1];
	assign prev_r  = rd_q[ENTRY_BITS-2 -: COUNT_BITS];
	assign curr_r  = rd_q[TIME_BITS+COUNT_BITS-1 -: COUNT_BITS];
	assign begin_r = rd_q[TIME_BITS-1:0];

	// An absent slot starts fresh with its window opening now.
	assign begin_eff = pres_r ? begin_r : now_q;
	assign elapsed   = now_q - begin_eff;
	assign roll      = CMP_BITS'(elapsed) >= CMP_BITS'(window_q);

	assign allow     = less;
	assign curr_next = (allow && (curr_q != '1)) ? curr_q + 1'b1 : curr_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
			end
			ST_IDLE: begin
				if (accept && in_range && (command == slwc_pkg::CMD_ERASE)) begin
					mem_we    = 1'b1;
					mem_waddr = in_idx;
				end
			end
			ST_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, prev_q, curr_next, begin_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[slot_q];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			ST_MUL1: begin
				mac_ctl.mul_en = 1'b1;
				mac_a          = MUL_A_BITS'(prev_q);
				mac_b          = window_q - e_q;
			end
			ST_MUL2: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_en = 1'b1;
				mac_a          = MUL_A_BITS'(curr_q);
				mac_b          = window_q;
			end
			ST_MUL3: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.acc_en  = 1'b1;
				mac_ctl.acc_add = 1'b1;
				mac_a           = MUL_A_BITS'(max_q);
				mac_b           = window_q;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	slwc_mac #(
		.A_BITS(MUL_A_BITS)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.less(less)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			slot_q <= in_idx;
			now_q  <= TIME_BITS'(now_time);
		end
		if (state_q == ST_EVAL) begin
			begin_q <= roll ? now_q : begin_eff;
			prev_q  <= !pres_r ? '0 : (roll ? curr_r : prev_r);
			curr_q  <= (!pres_r || roll) ? '0 : curr_r;
			e_q     <= roll ? '0 : slwc_pkg::WINDOW_BITS'(elapsed);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= slwc_pkg::WINDOW_RESET;
			max_q    <= slwc_pkg::MAX_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				slwc_pkg::REG_WINDOW: window_q <= cfg_data;
				slwc_pkg::REG_MAX:    max_q    <= cfg_data[slwc_pkg::MAX_BITS-1:0];
				default:              window_q <= window_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			done_q    <= 1'b0;
			allowed_q <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			allowed_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (32'(clr_idx_q) == 32'(CLIENTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!in_range || (command == slwc_pkg::CMD_ERASE)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_CMP;
				ST_CMP: begin
					done_q    <= 1'b1;
					allowed_q <= allow;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_CMP) || $past(start && !busy))
		else $error("result strobe without a finished command");

	a_allowed_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		allowed |-> done)
		else $error("allowed raised outside a result");

	a_cmp_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |=> done && !busy)
		else $error("request check did not answer after the compare");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done && busy)
		else $error("result or transfer during the clearing pass");
`endif

endmodule
